// ===== rtl/core/ezr_pkg.sv =====
`timescale 1ns / 1ps
package ezr_pkg;

  localparam int CordicSteps = 20;
  localparam int ZW = 34;
  localparam int XW = 33;

  localparam logic signed [ZW-1:0] AngPi     = 34'sd3373259426;
  localparam logic signed [ZW-1:0] AngHalfPi = 34'sd1686629713;
  localparam logic signed [XW-1:0] GainInv   = 33'sd652032874;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [17:0] q15_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } trans_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    trans_t             t;
  } pose_t;

  typedef struct packed {
    q15_t sx; q15_t cx;
    q15_t sy; q15_t cy;
    q15_t sz; q15_t cz;
    trans_t t;
  } trig_t;

  typedef struct packed {
    q14_t m00; q14_t m01; q14_t m02;
    q14_t m10; q14_t m11; q14_t m12;
    q14_t m20; q14_t m21; q14_t m22;
    trans_t t;
  } mat_t;

  function automatic logic signed [ZW-1:0] atan_c(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 34'sh3243F6A8;
      5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;
      5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;
      5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;
      5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;
      5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;
      5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;
      5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;
      5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;
      5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;
      default: r = 34'sh000007FF;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/euler_zyx_to_rotation_matrix.sv =====
`timescale 1ns / 1ps
// channel  | ports                                   | transfer
// in       | in_angle_x/y/z, in_trans_in_x/y/z       | in_valid && in_ready
// out      | out_m00..out_m22, out_trans_out_x/y/z   | out_valid && out_ready
// one pose per cycle sustained while out_ready stays high; a pose passes the cordic
// pipeline, its queue, the multiplier pipeline and then the output queue
// the cordic front writes into a queue read by the matrix back end
// synchronous active-low reset empties both pipelines and queues
// ready drops only when a queue's credits are used up by a stalled output
module euler_zyx_to_rotation_matrix #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  input  logic signed [31:0] in_trans_in_x,
  input  logic signed [31:0] in_trans_in_y,
  input  logic signed [31:0] in_trans_in_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_m00,
  output logic signed [15:0] out_m01,
  output logic signed [15:0] out_m02,
  output logic signed [15:0] out_m10,
  output logic signed [15:0] out_m11,
  output logic signed [15:0] out_m12,
  output logic signed [15:0] out_m20,
  output logic signed [15:0] out_m21,
  output logic signed [15:0] out_m22,
  output logic signed [31:0] out_trans_out_x,
  output logic signed [31:0] out_trans_out_y,
  output logic signed [31:0] out_trans_out_z
);
  ezr_pkg::pose_t pose;
  ezr_pkg::trig_t trig;
  ezr_pkg::mat_t  mat;
  logic tv, tr;

  assign pose.ax = in_angle_x;
  assign pose.ay = in_angle_y;
  assign pose.az = in_angle_z;
  assign pose.t.tx = in_trans_in_x;
  assign pose.t.ty = in_trans_in_y;
  assign pose.t.tz = in_trans_in_z;

  ezr_cordic #(.DEPTH(QDEPTH + 22)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pose(pose),
    .out_valid(tv), .out_ready(tr), .out_trig(trig)
  );

  ezr_matrix #(.DEPTH(QDEPTH + 3)) u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(tv), .in_ready(tr), .in_trig(trig),
    .out_valid(out_valid), .out_ready(out_ready), .out_mat(mat)
  );

  assign out_m00 = mat.m00;
  assign out_m01 = mat.m01;
  assign out_m02 = mat.m02;
  assign out_m10 = mat.m10;
  assign out_m11 = mat.m11;
  assign out_m12 = mat.m12;
  assign out_m20 = mat.m20;
  assign out_m21 = mat.m21;
  assign out_m22 = mat.m22;
  assign out_trans_out_x = mat.t.tx;
  assign out_trans_out_y = mat.t.ty;
  assign out_trans_out_z = mat.t.tz;

  a_m20_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_m20 <= 16'sd16384 && out_m20 >= -16'sd16384))
    else $error("m20 out of range");
  a_m00_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_m00 <= 16'sd16384 && out_m00 >= -16'sd16384))
    else $error("m00 out of range");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

// ===== rtl/core/ezr_fifo.sv =====
`timescale 1ns / 1ps
module ezr_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ===== rtl/core/ezr_cordic.sv =====
`timescale 1ns / 1ps
module ezr_cordic #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ezr_pkg::pose_t       in_pose,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ezr_pkg::trig_t       out_trig
);
  localparam int N = ezr_pkg::CordicSteps;
  localparam int ZW = ezr_pkg::ZW;
  localparam int XW = ezr_pkg::XW;
  localparam int L = N + 2;

  // pipeline with credit so the fifo never overflows
  localparam int CW = $clog2(DEPTH + L + 2) + 1;
  logic [CW-1:0] cred_r;
  logic acc, deq;

  logic [L-1:0] v_r;
  logic signed [XW-1:0] x_r [3][N+1];
  logic signed [XW-1:0] y_r [3][N+1];
  logic signed [ZW-1:0] z_r [3][N+1];
  logic [N:0] ng_r [3];
  ezr_pkg::trans_t t_r [N+2];
  ezr_pkg::q15_t s_r [3], c_r [3];
  logic fwr;

  assign in_ready = (cred_r != '0);
  assign acc = in_valid && in_ready;

  logic signed [ZW-1:0] za [3];
  logic signed [ZW-1:0] zf [3];
  logic nf [3];
  logic signed [15:0] ang [3];
  assign ang[0] = in_pose.ax;
  assign ang[1] = in_pose.ay;
  assign ang[2] = in_pose.az;

  function automatic ezr_pkg::q15_t rnd15(input logic signed [XW-1:0] v, input logic n);
    logic signed [XW:0] w;
    logic signed [XW:0] r;
    w = n ? -{v[XW-1], v} : {v[XW-1], v};
    r = (w + (XW+1)'(16384)) >>> 15;
    if (r > 32768) r = 32768;
    else if (r < -32768) r = -32768;
    return r[17:0];
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      za[k] = {{(ZW-33){ang[k][15]}}, ang[k], 17'd0};
      nf[k] = 1'b0;
      zf[k] = za[k];
      if (za[k] > ezr_pkg::AngHalfPi) begin
        zf[k] = za[k] - ezr_pkg::AngPi; nf[k] = 1'b1;
      end else if (za[k] < -ezr_pkg::AngHalfPi) begin
        zf[k] = za[k] + ezr_pkg::AngPi; nf[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[L-2:0], acc};
    end
    t_r[0] <= in_pose.t;
    for (int j = 1; j < N + 2; j++) t_r[j] <= t_r[j-1];
    for (int k = 0; k < 3; k++) begin
      x_r[k][0] <= ezr_pkg::GainInv;
      y_r[k][0] <= '0;
      z_r[k][0] <= zf[k];
      ng_r[k][0] <= nf[k];
      for (int i = 0; i < N; i++) begin
        ng_r[k][i+1] <= ng_r[k][i];
        if (!z_r[k][i][ZW-1]) begin
          x_r[k][i+1] <= x_r[k][i] - (y_r[k][i] >>> i);
          y_r[k][i+1] <= y_r[k][i] + (x_r[k][i] >>> i);
          z_r[k][i+1] <= z_r[k][i] - ezr_pkg::atan_c(5'(i));
        end else begin
          x_r[k][i+1] <= x_r[k][i] + (y_r[k][i] >>> i);
          y_r[k][i+1] <= y_r[k][i] - (x_r[k][i] >>> i);
          z_r[k][i+1] <= z_r[k][i] + ezr_pkg::atan_c(5'(i));
        end
      end
      c_r[k] <= rnd15(x_r[k][N], ng_r[k][N]);
      s_r[k] <= rnd15(y_r[k][N], ng_r[k][N]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cred_r <= CW'(DEPTH);
    else cred_r <= cred_r - CW'(acc) + CW'(deq);
  end

  assign fwr = v_r[L-1];
  ezr_pkg::trig_t tw;
  always_comb begin
    tw.sx = s_r[0]; tw.cx = c_r[0];
    tw.sy = s_r[1]; tw.cy = c_r[1];
    tw.sz = s_r[2]; tw.cz = c_r[2];
    tw.t = t_r[N+1];
  end

  logic unused_ready;
  ezr_fifo #(.W($bits(ezr_pkg::trig_t)), .DEPTH(DEPTH)) u_q (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fwr), .wr_ready(unused_ready), .wr_data(tw),
    .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(out_trig)
  );
  assign deq = out_valid && out_ready && !unused_ready | (out_valid && out_ready);
endmodule

// ===== rtl/core/ezr_matrix.sv =====
`timescale 1ns / 1ps
module ezr_matrix #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ezr_pkg::trig_t in_trig,
  output logic           out_valid,
  input  logic           out_ready,
  output ezr_pkg::mat_t  out_mat
);
  localparam int L = 3;
  localparam int CW = $clog2(DEPTH + L + 2) + 1;
  logic [CW-1:0] cred_r;
  logic acc, deq, fok;
  logic [L-1:0] v_r;

  assign in_ready = (cred_r != '0);
  assign acc = in_valid && in_ready;

  // stage 1: two-factor products
  logic signed [35:0] p_czcy, p_szcy, p_cysx, p_cycx, p_szsx, p_szcx, p_czsx, p_czcx;
  logic signed [35:0] p_czsy, p_szsy;
  logic signed [17:0] msy_r;
  ezr_pkg::q15_t sx1, cx1;
  // stage 2: three-factor terms
  logic signed [54:0] t1a, t1b, t1c, t1d;
  logic signed [35:0] u1a, u1b, u1c, u1d, q00, q10, q21, q22;
  logic signed [17:0] msy2;
  ezr_pkg::trans_t t1, t2;
  ezr_pkg::mat_t m_r;

  function automatic ezr_pkg::q14_t sat(input logic signed [56:0] v);
    if (v > 57'sd16384) return 16'sd16384;
    if (v < -57'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic ezr_pkg::q14_t r2(input logic signed [35:0] p);
    return sat(57'((p + 36'sd32768) >>> 16));
  endfunction

  function automatic ezr_pkg::q14_t r3(input logic signed [54:0] a,
                                       input logic signed [35:0] b, input logic add);
    logic signed [56:0] bb, s;
    bb = {{6{b[35]}}, b, 15'd0};
    s = add ? (57'(a) + bb) : (57'(a) - bb);
    return sat((s + 57'sd1073741824) >>> 31);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[L-2:0], acc};
    p_czcy <= in_trig.cz * in_trig.cy;
    p_szcy <= in_trig.sz * in_trig.cy;
    p_cysx <= in_trig.cy * in_trig.sx;
    p_cycx <= in_trig.cy * in_trig.cx;
    p_szsx <= in_trig.sz * in_trig.sx;
    p_szcx <= in_trig.sz * in_trig.cx;
    p_czsx <= in_trig.cz * in_trig.sx;
    p_czcx <= in_trig.cz * in_trig.cx;
    p_czsy <= in_trig.cz * in_trig.sy;
    p_szsy <= in_trig.sz * in_trig.sy;
    msy_r <= -in_trig.sy;
    sx1 <= in_trig.sx; cx1 <= in_trig.cx;
    t1 <= in_trig.t;

    t1a <= p_czsy * sx1;
    t1b <= p_czsy * cx1;
    t1c <= p_szsy * sx1;
    t1d <= p_szsy * cx1;
    u1a <= p_szcx; u1b <= p_szsx; u1c <= p_czcx; u1d <= p_czsx;
    q00 <= p_czcy; q10 <= p_szcy; q21 <= p_cysx; q22 <= p_cycx;
    msy2 <= msy_r; t2 <= t1;

    m_r.m00 <= r2(q00);
    m_r.m01 <= r3(t1a, u1a, 1'b0);
    m_r.m02 <= r3(t1b, u1b, 1'b1);
    m_r.m10 <= r2(q10);
    m_r.m11 <= r3(t1c, u1c, 1'b1);
    m_r.m12 <= r3(t1d, u1d, 1'b0);
    m_r.m20 <= sat(57'((msy2 + 18'sd1) >>> 1));
    m_r.m21 <= r2(q21);
    m_r.m22 <= r2(q22);
    m_r.t <= t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cred_r <= CW'(DEPTH);
    else cred_r <= cred_r - CW'(acc) + CW'(deq);
  end

  assign deq = out_valid && out_ready;
  ezr_fifo #(.W($bits(ezr_pkg::mat_t)), .DEPTH(DEPTH)) u_q (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(v_r[L-1]), .wr_ready(fok), .wr_data(m_r),
    .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(out_mat)
  );
  logic unused_fok;
  assign unused_fok = fok;
endmodule

// ===== dv/euler_zyx_to_rotation_matrix_test.sv =====
`timescale 1ns / 1ps
module euler_zyx_to_rotation_matrix_test;

  typedef struct {
    logic signed [15:0] m [9];
    logic signed [31:0] t [3];
  } pose_mat_t;

  function automatic longint rnd(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  // cordic sine/cosine of a q3.13 angle, results in q.15
  function automatic void sin_cos(input logic signed [15:0] ang,
                                  output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit fold;
    longint atn [20] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF};
    z = longint'(ang) * 131072;
    fold = 0;
    x = 652032874;
    y = 0;
    if (z > 1686629713) begin
      z -= 64'sd3373259426; fold = 1;
    end else if (z < -1686629713) begin
      z += 64'sd3373259426; fold = 1;
    end
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atn[i];
      end else begin
        x += dx; y -= dy; z += atn[i];
      end
    end
    if (fold) begin
      x = -x; y = -y;
    end
    c = sat(rnd(x, 15), 32768);
    s = sat(rnd(y, 15), 32768);
  endfunction

  function automatic longint mul2(longint a, longint b);
    return sat(rnd(a * b, 16), 16384);
  endfunction

  function automatic longint mul3(longint a, longint b, longint c, longint d,
                                  longint e, bit add);
    longint t1, t2;
    t1 = a * b * c;
    t2 = d * e * 32768;
    return sat(rnd(add ? t1 + t2 : t1 - t2, 31), 16384);
  endfunction

  function automatic pose_mat_t rotation_of(logic signed [15:0] ax, ay, az,
                                            logic signed [31:0] tx, ty, tz);
    pose_mat_t r;
    longint sx, cx, sy, cy, sz, cz;
    sin_cos(ax, sx, cx);
    sin_cos(ay, sy, cy);
    sin_cos(az, sz, cz);
    r.m[0] = 16'(mul2(cz, cy));
    r.m[1] = 16'(mul3(cz, sy, sx, sz, cx, 0));
    r.m[2] = 16'(mul3(cz, sy, cx, sz, sx, 1));
    r.m[3] = 16'(mul2(sz, cy));
    r.m[4] = 16'(mul3(sz, sy, sx, cz, cx, 1));
    r.m[5] = 16'(mul3(sz, sy, cx, cz, sx, 0));
    r.m[6] = 16'(sat(rnd(-sy, 1), 16384));
    r.m[7] = 16'(mul2(cy, sx));
    r.m[8] = 16'(mul2(cy, cx));
    r.t[0] = tx; r.t[1] = ty; r.t[2] = tz;
    return r;
  endfunction

  class matrix_scoreboard;
    pose_mat_t pending[$];
    int errors = 0;
    int checked = 0;

    function void note_pose(pose_mat_t e);
      pending.push_back(e);
    endfunction

    function void check_matrix(pose_mat_t a);
      pose_mat_t e;
      bit bad;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      bad = 0;
      for (int k = 0; k < 9; k++) if (a.m[k] !== e.m[k]) bad = 1;
      for (int k = 0; k < 3; k++) if (a.t[k] !== e.t[k]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected m=%p t=%p, got m=%p t=%p",
                   checked, e.m, e.t, a.m, a.t);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_angle_x = 0, in_angle_y = 0, in_angle_z = 0;
  logic signed [31:0] in_trans_in_x = 0, in_trans_in_y = 0, in_trans_in_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [15:0] out_m20, out_m21, out_m22;
  logic signed [31:0] out_trans_out_x, out_trans_out_y, out_trans_out_z;

  matrix_scoreboard sb = new();
  bit stim_done = 0;
  longint cycles = 0;

  always #2 clk = ~clk;

  euler_zyx_to_rotation_matrix uut (.*);

  always @(posedge clk) cycles <= cycles + 1;

  // record each accepted pose and each accepted matrix
  always @(posedge clk) begin
    pose_mat_t a;
    if (rst_n && in_valid && in_ready)
      sb.note_pose(rotation_of(in_angle_x, in_angle_y, in_angle_z,
                               in_trans_in_x, in_trans_in_y, in_trans_in_z));
    if (rst_n && out_valid && out_ready) begin
      a.m = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12,
              out_m20, out_m21, out_m22};
      a.t = '{out_trans_out_x, out_trans_out_y, out_trans_out_z};
      sb.check_matrix(a);
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int mode;
    mode = int'((cycles / 300) % 3);
    if (!rst_n) out_ready <= 0;
    else if (mode == 0) out_ready <= 1;
    else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 9) < 3);
  end

  task automatic send_pose(logic signed [15:0] ax, ay, az,
                           logic signed [31:0] tx, ty, tz);
    in_valid <= 1;
    in_angle_x <= ax; in_angle_y <= ay; in_angle_z <= az;
    in_trans_in_x <= tx; in_trans_in_y <= ty; in_trans_in_z <= tz;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return 16'(-32768 + $urandom_range(0, 3));
      1: return 16'(32767 - $urandom_range(0, 3));
      // near the fold points at +-pi/2
      2: return 16'(($urandom_range(0, 1) ? 12868 : -12868) + $urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] d [12] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd12868,
      -16'sd12868, 16'sd12867, 16'sd25736, -16'sd25736, 16'sd6434, -16'sd6434,
      16'sd1, -16'sd1};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 12; i++)
      send_pose(d[i], d[(i + 3) % 12], d[(i + 7) % 12],
                32'h7FFFFFFF, 32'h80000000, i[0] ? 32'hFFFFFFFF : 32'h0);
    send_pose(16'sd32767, 16'sd32767, 16'sd32767, 0, 0, 0);
    send_pose(-16'sd32768, -16'sd32768, -16'sd32768, -1, -1, -1);
    send_pose(16'sd12868, 16'sd12868, -16'sd12868, 32'h55555555, 32'hAAAAAAAA, 1);
    for (int n = 0; n < 750;) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 750; b++, n++)
        send_pose(pick_angle(), pick_angle(), pick_angle(),
                  $urandom, $urandom, $urandom);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0 && cycles < 200000) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    $display("checked %0d rotation matrices over %0d cycles, %0d errors",
             sb.checked, cycles, sb.errors);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    wait (cycles >= 300000);
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/ezr_pkg.sv
rtl/core/ezr_fifo.sv
rtl/core/ezr_cordic.sv
rtl/core/ezr_matrix.sv
rtl/core/euler_zyx_to_rotation_matrix.sv
dv/euler_zyx_to_rotation_matrix_test.sv
